>>> src/dav_pkg.sv
`timescale 1ns / 1ps
// Package for the depth averaged velocity block: field widths, fixed-point
// constants and the request and response types of the serial divider.
// It depends on nothing else.
package dav_pkg;

    localparam int COORD_W     = 32;
    localparam int ELEV_W      = COORD_W + 1;
    localparam int DZ_W        = ELEV_W + 1;
    localparam int VEL_W       = 24;
    localparam int VSUM_W      = VEL_W + 1;
    localparam int DIG_W       = (DZ_W + 1) / 2;
    localparam int MUL_W       = VSUM_W + DIG_W + 1;
    localparam int SUM_W       = 64;
    localparam int TERM_SHIFT  = 9;
    localparam int SCALE_BITS  = 8;
    localparam int QUOT_W      = VEL_W;
    localparam int LOWB        = QUOT_W - SCALE_BITS;
    localparam int DIV_W       = ELEV_W;
    localparam int DEPTH_OUT_W = 32;
    localparam int COL_W       = 16;
    localparam int IN_TDATA_W  = 2 * COORD_W + 2 * VEL_W;
    localparam int OUT_TDATA_W = 2 * VEL_W + DEPTH_OUT_W + COL_W;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [SUM_W-1:0] mag;
        logic [DIV_W-1:0] divisor;
    } dav_div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [QUOT_W-1:0] quot;
    } dav_div_rsp_t;

endpackage

>>> src/dav_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider that turns one Q.24 sum and a depth into a
// saturated Q8.16 average, one quotient bit per cycle.
// It depends on dav_pkg.
module dav_div
    import dav_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  dav_div_req_t req,
    output dav_div_rsp_t rsp
);

    localparam int CNT_W = $clog2(QUOT_W + 1);
    localparam logic signed [QUOT_W-1:0] QMAX = {1'b0, {(QUOT_W-1){1'b1}}};
    localparam logic signed [QUOT_W-1:0] QMIN = {1'b1, {(QUOT_W-1){1'b0}}};

    logic [DIV_W-1:0]         rem_reg;
    logic [QUOT_W-1:0]        sh_reg;
    logic [DIV_W-1:0]         d_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic signed [QUOT_W-1:0] quot_reg;

    logic [DIV_W:0]           trial;
    logic [DIV_W:0]           diff;
    logic                     ge;
    logic                     ovf_next;
    logic signed [QUOT_W-1:0] quot_next;

    assign trial    = {rem_reg, sh_reg[QUOT_W-1]};
    assign diff     = trial - {1'b0, d_reg};
    assign ge       = trial >= {1'b0, d_reg};
    assign ovf_next = req.mag[SUM_W-1:LOWB] >= {{(SUM_W-LOWB-DIV_W){1'b0}}, req.divisor};

    always_comb begin
        if (!neg_reg) begin
            quot_next = (ovf_reg || sh_reg[QUOT_W-1]) ? QMAX : sh_reg;
        end else if (ovf_reg || (sh_reg[QUOT_W-1] && (|sh_reg[QUOT_W-2:0]))) begin
            quot_next = QMIN;
        end else begin
            quot_next = -sh_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            fin_reg  <= !req.start && (cnt_reg == CNT_W'(1));
            done_reg <= fin_reg;
            if (req.start) begin
                rem_reg <= req.mag[LOWB+DIV_W-1:LOWB];
                sh_reg  <= {req.mag[LOWB-1:0], {SCALE_BITS{1'b0}}};
                d_reg   <= req.divisor;
                neg_reg <= req.neg;
                ovf_reg <= ovf_next;
                cnt_reg <= CNT_W'(QUOT_W);
            end else if (cnt_reg != '0) begin
                rem_reg <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                sh_reg  <= {sh_reg[QUOT_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (fin_reg) begin
                quot_reg <= quot_next;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> src/depth_average_velocity_top.sv
`timescale 1ns / 1ps
// Top level of the depth averaged velocity block: node intake, trapezoid
// integration and result register. It depends on dav_pkg and dav_div.
//
// Nodes of a column arrive top to bottom, one beat each, with tlast on the
// bottom node. A column top skips the multiplier; every further node uses the
// single 25 by 18 bit multiplier that forms four partial products per node
// (two digits of the elevation step for each velocity component). A bottom
// node with a positive depth waits on the two bit-serial dividers that run
// side by side, one quotient bit per cycle. One result beat leaves per column;
// the next node is taken while that beat still waits on the output side, and
// the block only stalls if a second result is ready before the first is taken.
module depth_average_velocity_top
    import dav_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // bed_coord, surface_shift, vel_east, vel_north
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // avg_east, avg_north, water_depth, column_number
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // status
    output logic                   m_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_TAIL  = 3'd3;
    localparam logic [2:0] ST_DIVGO = 3'd4;
    localparam logic [2:0] ST_DIVW  = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] MUL_LAST = 3'd5;

    localparam logic signed [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W-1:0] s;
        s = a + b;
        if (a[SUM_W-1] == b[SUM_W-1] && s[SUM_W-1] != a[SUM_W-1]) begin
            s = a[SUM_W-1] ? SMIN : SMAX;
        end
        return s;
    endfunction

    logic [2:0]                state_reg;
    logic [2:0]                cnt_reg;
    logic                      inside_reg;
    logic [COL_W-1:0]          col_reg;
    logic                      last_reg;
    logic signed [ELEV_W-1:0]  elev_reg;
    logic signed [VEL_W-1:0]   ve_reg;
    logic signed [VEL_W-1:0]   vn_reg;
    logic signed [ELEV_W-1:0]  prev_elev_reg;
    logic signed [VEL_W-1:0]   prev_east_reg;
    logic signed [VEL_W-1:0]   prev_north_reg;
    logic signed [ELEV_W-1:0]  surface_reg;
    logic signed [DZ_W-1:0]    dz_reg;
    logic signed [VSUM_W-1:0]  vs_e_reg;
    logic signed [VSUM_W-1:0]  vs_n_reg;
    logic signed [MUL_W-1:0]   mul_reg;
    logic signed [SUM_W-1:0]   term_reg;
    logic signed [SUM_W-1:0]   sum_e_reg;
    logic signed [SUM_W-1:0]   sum_n_reg;
    logic signed [DZ_W-1:0]    depth_reg;
    logic                      status_reg;
    logic                      m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]    m_tdata_reg;
    logic                      m_tuser_reg;

    logic signed [ELEV_W-1:0]  elev_next;
    logic signed [VSUM_W-1:0]  vs_sel;
    logic signed [DIG_W:0]     dig_sel;
    logic signed [MUL_W-1:0]   mul_next;
    logic signed [SUM_W-1:0]   mul_ext;
    logic signed [SUM_W-1:0]   addend;
    logic                      depth_pos;
    logic                      out_free;
    logic [DEPTH_OUT_W-1:0]    depth_out;
    dav_div_req_t              req_e;
    dav_div_req_t              req_n;
    dav_div_rsp_t              rsp_e;
    dav_div_rsp_t              rsp_n;

    assign elev_next = {s_tdata[COORD_W-1], s_tdata[COORD_W-1:0]}
                     + {s_tdata[2*COORD_W-1], s_tdata[2*COORD_W-1:COORD_W]};

    assign vs_sel   = cnt_reg[1] ? vs_n_reg : vs_e_reg;
    assign dig_sel  = cnt_reg[0] ? {dz_reg[DZ_W-1], dz_reg[DZ_W-1:DIG_W]}
                                 : {1'b0, dz_reg[DIG_W-1:0]};
    assign mul_next = vs_sel * dig_sel;
    assign mul_ext  = {{(SUM_W-MUL_W){mul_reg[MUL_W-1]}}, mul_reg};
    assign addend   = term_reg >>> TERM_SHIFT;

    assign depth_pos = !depth_reg[DZ_W-1] && (depth_reg != '0);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign depth_out = !status_reg
                     ? (depth_reg[DEPTH_OUT_W] ? {DEPTH_OUT_W{1'b1}}
                                               : depth_reg[DEPTH_OUT_W-1:0])
                     : '0;

    assign req_e.start   = (state_reg == ST_DIVGO) && depth_pos;
    assign req_e.neg     = sum_e_reg[SUM_W-1];
    assign req_e.mag     = sum_e_reg[SUM_W-1] ? -sum_e_reg : sum_e_reg;
    assign req_e.divisor = depth_reg[DIV_W-1:0];
    assign req_n.start   = req_e.start;
    assign req_n.neg     = sum_n_reg[SUM_W-1];
    assign req_n.mag     = sum_n_reg[SUM_W-1] ? -sum_n_reg : sum_n_reg;
    assign req_n.divisor = depth_reg[DIV_W-1:0];

    dav_div u_div_e (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_e),
        .rsp     (rsp_e)
    );

    dav_div u_div_n (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_n),
        .rsp     (rsp_n)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            inside_reg     <= 1'b0;
            col_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            prev_elev_reg  <= '0;
            prev_east_reg  <= '0;
            prev_north_reg <= '0;
            surface_reg    <= '0;
            sum_e_reg      <= '0;
            sum_n_reg      <= '0;
        end else begin
            if ((state_reg == ST_EMIT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        elev_reg  <= elev_next;
                        ve_reg    <= s_tdata[2*COORD_W+VEL_W-1:2*COORD_W];
                        vn_reg    <= s_tdata[IN_TDATA_W-1:2*COORD_W+VEL_W];
                        last_reg  <= s_tlast;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    if (!inside_reg) begin
                        surface_reg <= elev_reg;
                        sum_e_reg   <= '0;
                        sum_n_reg   <= '0;
                        state_reg   <= ST_TAIL;
                    end else begin
                        dz_reg    <= {prev_elev_reg[ELEV_W-1], prev_elev_reg}
                                   - {elev_reg[ELEV_W-1], elev_reg};
                        vs_e_reg  <= {prev_east_reg[VEL_W-1], prev_east_reg}
                                   + {ve_reg[VEL_W-1], ve_reg};
                        vs_n_reg  <= {prev_north_reg[VEL_W-1], prev_north_reg}
                                   + {vn_reg[VEL_W-1], vn_reg};
                        cnt_reg   <= '0;
                        state_reg <= ST_MUL;
                    end
                    prev_elev_reg  <= elev_reg;
                    prev_east_reg  <= ve_reg;
                    prev_north_reg <= vn_reg;
                end
                ST_MUL: begin
                    mul_reg <= mul_next;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 3'd1 || cnt_reg == 3'd3) begin
                        term_reg <= mul_ext;
                    end else if (cnt_reg == 3'd2 || cnt_reg == 3'd4) begin
                        term_reg <= term_reg + (mul_ext <<< DIG_W);
                    end
                    if (cnt_reg == 3'd3) begin
                        sum_e_reg <= sat_add(sum_e_reg, addend);
                    end
                    if (cnt_reg == MUL_LAST) begin
                        sum_n_reg <= sat_add(sum_n_reg, addend);
                        state_reg <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    if (!last_reg) begin
                        inside_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end else begin
                        depth_reg <= {surface_reg[ELEV_W-1], surface_reg}
                                   - {elev_reg[ELEV_W-1], elev_reg};
                        state_reg <= ST_DIVGO;
                    end
                end
                ST_DIVGO: begin
                    status_reg <= !depth_pos;
                    state_reg  <= depth_pos ? ST_DIVW : ST_EMIT;
                end
                ST_DIVW: begin
                    if (rsp_e.done) begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tuser_reg  <= status_reg;
                        m_tdata_reg  <= {col_reg, depth_out,
                                         status_reg ? {VEL_W{1'b0}} : rsp_n.quot,
                                         status_reg ? {VEL_W{1'b0}} : rsp_e.quot};
                        col_reg      <= col_reg + 1'b1;
                        inside_reg   <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> src/dav_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the depth averaged velocity block and the bind that
// attaches it to the top level. It depends on dav_pkg.
module dav_checker
    import dav_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [IN_TDATA_W-1:0]  s_tdata,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    localparam int DEPTH_LO = 2 * VEL_W;
    localparam int DEPTH_HI = 2 * VEL_W + DEPTH_OUT_W - 1;

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("Result beat withdrawn before it was taken.");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("Result beat changed while stalled.");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[DEPTH_HI:0] == '0)
        else $error("Failed column reports non-zero averages or depth.");

    a_ok_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[DEPTH_HI:DEPTH_LO] != '0)
        else $error("Good column reports zero depth.");

endmodule

bind depth_average_velocity_top dav_checker u_dav_checker (.*);
